// ===== sv/ddpd_pkg.sv =====
package ddpd_pkg;

    localparam int SUM_W = 48;
    localparam int GAIN_W = 24;

    localparam logic [3:0] REG_FWD_P = 4'd0;
    localparam logic [3:0] REG_FWD_D = 4'd1;
    localparam logic [3:0] REG_ROT_P = 4'd2;
    localparam logic [3:0] REG_ROT_D = 4'd3;
    localparam logic [3:0] REG_TICK = 4'd4;
    localparam logic [3:0] REG_VMAX = 4'd5;
    localparam logic [3:0] REG_FULL = 4'd6;
    localparam logic [3:0] REG_CEIL = 4'd7;

    localparam logic [1:0] DIR_KEEP = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;
    localparam logic [1:0] DIR_BRAKE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,
        ST_SUM,
        ST_PD,
        ST_MIX,
        ST_DIVLD,
        ST_DIV,
        ST_DONE,
        ST_OUT
    } t_state;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic       load;
        logic       inc;
        logic       sum;
        logic       pd_step;
        logic [1:0] pd_sel;
        logic       mix;
        logic       div_load;
        logic       div_step;
        logic       finish;
        logic       stop;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

// ===== sv/ddpd_ctrl.sv =====
module ddpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_action,
    input  logic              i_out_ready,
    input  ddpd_pkg::t_status i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output ddpd_pkg::t_cmd    o_cmd
);

    ddpd_pkg::t_state r_state, n_state;
    logic [1:0] r_pd, n_pd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddpd_pkg::ST_IDLE;
            r_pd <= '0;
        end else begin
            r_state <= n_state;
            r_pd <= n_pd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pd = r_pd;
        o_cmd = '0;
        o_cmd.pd_sel = r_pd;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ddpd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_action ? ddpd_pkg::ST_DONE : ddpd_pkg::ST_INC;
                    o_cmd.stop = i_action;
                end
            end
            ddpd_pkg::ST_INC: begin
                o_cmd.inc = 1'b1;
                n_state = ddpd_pkg::ST_SUM;
            end
            ddpd_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_pd = '0;
                n_state = ddpd_pkg::ST_PD;
            end
            ddpd_pkg::ST_PD: begin
                o_cmd.pd_step = 1'b1;
                n_pd = r_pd + 2'd1;
                if (r_pd == 2'd3) n_state = ddpd_pkg::ST_MIX;
            end
            ddpd_pkg::ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state = ddpd_pkg::ST_DIVLD;
            end
            ddpd_pkg::ST_DIVLD: begin
                o_cmd.div_load = 1'b1;
                n_state = ddpd_pkg::ST_DIV;
            end
            ddpd_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = ddpd_pkg::ST_DONE;
            end
            ddpd_pkg::ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = ddpd_pkg::ST_OUT;
            end
            ddpd_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ddpd_pkg::ST_IDLE;
            end
            default: n_state = ddpd_pkg::ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ddpd_pkg::ST_IDLE) else $error("ready outside idle");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
`endif

endmodule

// ===== sv/ddpd_datapath.sv =====
module ddpd_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ddpd_pkg::t_cmd     i_cmd,
    output ddpd_pkg::t_status  o_status,
    input  logic [23:0]        i_kfp,
    input  logic [23:0]        i_kfd,
    input  logic [23:0]        i_krp,
    input  logic [23:0]        i_krd,
    input  logic [23:0]        i_tick,
    input  logic [15:0]        i_vmax,
    input  logic [15:0]        i_full,
    input  logic [15:0]        i_ceil,
    input  logic signed [23:0] i_speed_cmd,
    input  logic signed [23:0] i_turn_rate_cmd,
    input  logic signed [31:0] i_steering,
    input  logic signed [31:0] i_moved_forward,
    input  logic signed [31:0] i_moved_rotation,
    input  logic               i_profile_idle,
    input  logic               i_drive_enable,
    input  logic [15:0]        i_battery_volts,
    output logic               o_drive_written,
    output logic [15:0]        o_left_duty,
    output logic [1:0]         o_left_dir,
    output logic [15:0]        o_right_duty,
    output logic [1:0]         o_right_dir,
    output logic signed [16:0] o_left_volts,
    output logic signed [16:0] o_right_volts
);

    localparam logic signed [49:0] SMAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] SMIN = -50'sh0_8000_0000_0000;

    logic signed [23:0] r_spd, r_trn;
    logic signed [31:0] r_str, r_mf, r_mr;
    logic r_pidle, r_en;
    logic [15:0] r_batt;
    logic signed [47:0] r_fsum, r_rsum;
    logic signed [32:0] r_incf, r_incr;
    logic signed [48:0] r_df, r_dr;
    logic signed [53:0] r_term [4];
    logic signed [16:0] r_lv, r_rv;
    logic [32:0] r_remL, r_remR;
    logic [31:0] r_qL, r_qR;
    logic [31:0] r_numL, r_numR;
    logic [5:0] r_cnt;
    logic r_stop;

    // increments: Q8 * Q24 truncated toward zero to Q16
    function automatic logic signed [32:0] f_inc(input logic signed [23:0] s,
                                                 input logic [23:0] t);
        logic signed [48:0] p;
        logic [48:0] m;
        begin
            p = s * $signed({1'b0, t});
            m = p[48] ? 49'(-p) : 49'(p);
            m = m >> 16;
            f_inc = p[48] ? -$signed(33'(m)) : $signed(33'(m));
        end
    endfunction

    function automatic logic signed [47:0] f_sat(input logic signed [49:0] v);
        begin
            if (v > SMAX) f_sat = SMAX[47:0];
            else if (v < SMIN) f_sat = SMIN[47:0];
            else f_sat = v[47:0];
        end
    endfunction

    function automatic logic signed [17:0] f_clamp(input logic signed [55:0] v,
                                                   input logic [15:0] m);
        logic signed [55:0] mx;
        begin
            mx = $signed({40'd0, m});
            if (v > mx) f_clamp = 18'(mx);
            else if (v < -mx) f_clamp = 18'(-mx);
            else f_clamp = 18'(v);
        end
    endfunction

    // PD operand selection; one 49x24 product per step, split in two halves
    logic signed [48:0] pd_err;
    logic [23:0] pd_gain;
    logic [48:0] pd_mag;
    logic [48:0] pd_hi_p, pd_lo_p;
    logic [52:0] pd_r;
    always_comb begin
        case (i_cmd.pd_sel)
            2'd0: begin pd_err = 49'(r_fsum); pd_gain = i_kfp; end
            2'd1: begin pd_err = r_df; pd_gain = i_kfd; end
            2'd2: begin pd_err = 49'(r_rsum); pd_gain = i_krp; end
            default: begin pd_err = r_dr; pd_gain = i_krd; end
        endcase
        pd_mag = pd_err[48] ? 49'(-pd_err) : 49'(pd_err);
        pd_hi_p = 49'(pd_mag[48:24]) * 49'(pd_gain);
        pd_lo_p = 49'(pd_mag[23:0]) * 49'(pd_gain);
        pd_r = (53'(pd_hi_p) << 4) + 53'(pd_lo_p >> 20);
    end

    logic signed [49:0] nf, nr;
    logic signed [47:0] sf, sr;
    logic signed [54:0] fwd, rot;
    logic signed [17:0] lv, rv;
    always_comb begin
        nf = 50'(r_fsum) + 50'(r_incf) - 50'(r_mf);
        nr = 50'(r_rsum) + 50'(r_incr) - 50'(r_mr) + (r_pidle ? 50'(r_str) : 50'sd0);
        sf = f_sat(nf);
        sr = f_sat(nr);
        fwd = 55'(r_term[0]) + 55'(r_term[1]);
        rot = 55'(r_term[2]) + 55'(r_term[3]);
        lv = f_clamp(fwd - rot, i_vmax);
        rv = f_clamp(fwd + rot, i_vmax);
    end

    // restoring division, both motors in parallel, one quotient bit a cycle
    logic [15:0] bdiv;
    logic [32:0] trL, trR;
    always_comb begin
        bdiv = (r_batt == 16'd0) ? 16'd1 : r_batt;
        trL = {r_remL[31:0], r_numL[31]};
        trR = {r_remR[31:0], r_numR[31]};
    end
    assign o_status.div_done = (r_cnt == 6'd31);

    function automatic logic [15:0] f_duty(input logic [31:0] q, input logic [15:0] c);
        f_duty = (q > 32'(c)) ? c : q[15:0];
    endfunction
    function automatic logic [1:0] f_dir(input logic [31:0] q, input logic neg);
        if (q == 32'd0) f_dir = ddpd_pkg::DIR_KEEP;
        else f_dir = neg ? ddpd_pkg::DIR_REV : ddpd_pkg::DIR_FWD;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsum <= '0;
            r_rsum <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_spd <= i_speed_cmd; r_trn <= i_turn_rate_cmd;
                r_str <= i_steering; r_mf <= i_moved_forward; r_mr <= i_moved_rotation;
                r_pidle <= i_profile_idle; r_en <= i_drive_enable;
                r_batt <= i_battery_volts;
            end
            if (i_cmd.inc) begin
                r_incf <= f_inc(r_spd, i_tick);
                r_incr <= f_inc(r_trn, i_tick);
            end
            if (i_cmd.sum) begin
                r_df <= 49'(sf) - 49'(r_fsum);
                r_dr <= 49'(sr) - 49'(r_rsum);
                r_fsum <= sf;
                r_rsum <= sr;
            end
            if (i_cmd.pd_step)
                r_term[i_cmd.pd_sel] <= pd_err[48] ? -$signed({1'b0, pd_r})
                                                   : $signed({1'b0, pd_r});
            if (i_cmd.mix) begin
                r_lv <= lv[16:0];
                r_rv <= rv[16:0];
            end
            if (i_cmd.div_load) begin
                r_numL <= 32'(i_full) * 32'(r_lv[16] ? 17'(-r_lv) : r_lv);
                r_numR <= 32'(i_full) * 32'(r_rv[16] ? 17'(-r_rv) : r_rv);
                r_remL <= '0; r_remR <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 6'd1;
                r_numL <= r_numL << 1;
                r_numR <= r_numR << 1;
                if (trL >= 33'(bdiv)) begin
                    r_remL <= trL - 33'(bdiv); r_qL <= {r_qL[30:0], 1'b1};
                end else begin
                    r_remL <= trL; r_qL <= {r_qL[30:0], 1'b0};
                end
                if (trR >= 33'(bdiv)) begin
                    r_remR <= trR - 33'(bdiv); r_qR <= {r_qR[30:0], 1'b1};
                end else begin
                    r_remR <= trR; r_qR <= {r_qR[30:0], 1'b0};
                end
            end
            if (i_cmd.finish) begin
                if (r_stop) begin
                    o_drive_written <= 1'b1;
                    o_left_duty <= '0; o_right_duty <= '0;
                    o_left_dir <= ddpd_pkg::DIR_BRAKE; o_right_dir <= ddpd_pkg::DIR_BRAKE;
                    o_left_volts <= '0; o_right_volts <= '0;
                end else begin
                    o_drive_written <= r_en;
                    o_left_duty <= r_en ? f_duty(r_qL, i_ceil) : 16'd0;
                    o_right_duty <= r_en ? f_duty(r_qR, i_ceil) : 16'd0;
                    o_left_dir <= r_en ? f_dir(r_qL, r_lv[16]) : ddpd_pkg::DIR_KEEP;
                    o_right_dir <= r_en ? f_dir(r_qR, r_rv[16]) : ddpd_pkg::DIR_KEEP;
                    o_left_volts <= r_lv;
                    o_right_volts <= r_rv;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_stop <= 1'b0;
        else if (i_cmd.load) r_stop <= i_cmd.stop;
    end

`ifndef NO_ASSERTIONS
    a_stop_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |-> !i_cmd.sum) else $error("stop changed sums");
    a_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && r_stop |=> o_left_dir == ddpd_pkg::DIR_BRAKE)
        else $error("stop without brake");
    a_ceil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.finish) && !r_stop |-> o_left_duty <= i_ceil)
        else $error("duty above ceiling");
`endif

endmodule

// ===== sv/differential_drive_pd_controller_core.sv =====
// Differential-drive PD motor controller.
// Input channel (i_in_valid/o_in_ready) takes one control tick or stop
// action per transfer; output channel (o_out_valid/i_out_ready) returns
// exactly one result per transfer, in order.
// Configuration is to be written through the APB-style port while idle;
// the block itself does not enforce this. Registers sit at byte addresses
// 4*i and read back their current value. A control tick runs increment,
// error-sum update, four PD products through shared multiply logic, mixing,
// then a 32-step restoring division by the battery voltage that sets most
// of the latency. A stop action goes from acceptance straight to the
// finish step. One item is handled at a time; the next is accepted in the
// cycle after the result is taken.
// When the receiver stalls, the result holds and no input is accepted.
// Synchronous reset clears both error sums and restores the register
// defaults; no result is pending after reset.
module differential_drive_pd_controller_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic signed [23:0] i_speed_cmd,
    input  logic signed [23:0] i_turn_rate_cmd,
    input  logic signed [31:0] i_steering,
    input  logic signed [31:0] i_moved_forward,
    input  logic signed [31:0] i_moved_rotation,
    input  logic               i_profile_idle,
    input  logic               i_drive_enable,
    input  logic [15:0]        i_battery_volts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_drive_written,
    output logic [15:0]        o_left_duty,
    output logic [1:0]         o_left_dir,
    output logic [15:0]        o_right_duty,
    output logic [1:0]         o_right_dir,
    output logic signed [16:0] o_left_volts,
    output logic signed [16:0] o_right_volts,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [23:0] r_kfp, r_kfd, r_krp, r_krd, r_tick;
    logic [15:0] r_vmax, r_full, r_ceil;
    logic [3:0] widx;

    assign pready = 1'b1;
    assign widx = {1'b0, paddr[4:2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kfp <= 24'd81626; r_kfd <= 24'd892517;
            r_krp <= 24'd62790; r_krd <= 24'd686550;
            r_tick <= 24'd33554; r_vmax <= 16'd24576;
            r_full <= 16'd2047; r_ceil <= 16'd1473;
        end else if (psel && penable && pwrite) begin
            unique case (widx)
                ddpd_pkg::REG_FWD_P: r_kfp <= pwdata[23:0];
                ddpd_pkg::REG_FWD_D: r_kfd <= pwdata[23:0];
                ddpd_pkg::REG_ROT_P: r_krp <= pwdata[23:0];
                ddpd_pkg::REG_ROT_D: r_krd <= pwdata[23:0];
                ddpd_pkg::REG_TICK: r_tick <= pwdata[23:0];
                ddpd_pkg::REG_VMAX: r_vmax <= pwdata[15:0];
                ddpd_pkg::REG_FULL: r_full <= pwdata[15:0];
                ddpd_pkg::REG_CEIL: r_ceil <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            ddpd_pkg::REG_FWD_P: prdata = {8'd0, r_kfp};
            ddpd_pkg::REG_FWD_D: prdata = {8'd0, r_kfd};
            ddpd_pkg::REG_ROT_P: prdata = {8'd0, r_krp};
            ddpd_pkg::REG_ROT_D: prdata = {8'd0, r_krd};
            ddpd_pkg::REG_TICK: prdata = {8'd0, r_tick};
            ddpd_pkg::REG_VMAX: prdata = {16'd0, r_vmax};
            ddpd_pkg::REG_FULL: prdata = {16'd0, r_full};
            ddpd_pkg::REG_CEIL: prdata = {16'd0, r_ceil};
            default: prdata = '0;
        endcase
    end

    ddpd_pkg::t_cmd cmd;
    ddpd_pkg::t_status status;

    ddpd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_action(i_action), .i_out_ready(i_out_ready),
        .i_status(status), .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
        .o_cmd(cmd)
    );

    ddpd_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_kfp(r_kfp), .i_kfd(r_kfd), .i_krp(r_krp), .i_krd(r_krd),
        .i_tick(r_tick), .i_vmax(r_vmax), .i_full(r_full), .i_ceil(r_ceil),
        .i_speed_cmd(i_speed_cmd), .i_turn_rate_cmd(i_turn_rate_cmd),
        .i_steering(i_steering), .i_moved_forward(i_moved_forward),
        .i_moved_rotation(i_moved_rotation), .i_profile_idle(i_profile_idle),
        .i_drive_enable(i_drive_enable), .i_battery_volts(i_battery_volts),
        .o_drive_written(o_drive_written), .o_left_duty(o_left_duty),
        .o_left_dir(o_left_dir), .o_right_duty(o_right_duty),
        .o_right_dir(o_right_dir), .o_left_volts(o_left_volts),
        .o_right_volts(o_right_volts)
    );

endmodule

// ===== tb/tb_differential_drive_pd_controller_core.sv =====
module tb_differential_drive_pd_controller_core;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        action;
        logic [23:0] speed;
        logic [23:0] turn;
        logic [31:0] steer;
        logic [31:0] moved_fwd;
        logic [31:0] moved_rot;
        logic        prof_idle;
        logic        enable;
        logic [15:0] batt;
    } t_tick;

    typedef struct {
        logic        written;
        logic [15:0] l_duty;
        logic [1:0]  l_dir;
        logic [15:0] r_duty;
        logic [1:0]  r_dir;
        logic [16:0] l_volts;
        logic [16:0] r_volts;
    } t_drive;

    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -64'sh0000_7FFF_FFFF_FFFF - 1;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_tick       cur;
    logic        out_valid;
    logic        out_ready;
    logic        drive_written;
    logic [15:0] left_duty;
    logic [1:0]  left_dir;
    logic [15:0] right_duty;
    logic [1:0]  right_dir;
    logic signed [16:0] left_volts;
    logic signed [16:0] right_volts;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_tick  pending_ticks[$];
    t_drive expected_drives[$];
    logic [23:0] gain_reg[8];
    longint fwd_sum;
    longint rot_sum;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     errors;
    longint cycle_count;
    logic   in_ready_seen;
    logic   in_fire;
    logic   hold_sender;

    differential_drive_pd_controller_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_action        (cur.action),
        .i_speed_cmd     (cur.speed),
        .i_turn_rate_cmd (cur.turn),
        .i_steering      (cur.steer),
        .i_moved_forward (cur.moved_fwd),
        .i_moved_rotation(cur.moved_rot),
        .i_profile_idle  (cur.prof_idle),
        .i_drive_enable  (cur.enable),
        .i_battery_volts (cur.batt),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_drive_written (drive_written),
        .o_left_duty     (left_duty),
        .o_left_dir      (left_dir),
        .o_right_duty    (right_duty),
        .o_right_dir     (right_dir),
        .o_left_volts    (left_volts),
        .o_right_volts   (right_volts),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint trunc_q16(longint p);
        if (p < 0) begin
            return -((-p) >>> 16);
        end
        return p >>> 16;
    endfunction

    // Gain times error, Q16 by Q16 down to Q12, magnitude truncated.
    function automatic longint pd_volts(longint err, logic [23:0] gain);
        longint unsigned mag;
        longint unsigned r;
        mag = (err < 0) ? longint'(-err) : longint'(err);
        r = (((mag >> 24) * gain) << 4) + (((mag & 64'hFF_FFFF) * gain) >> 20);
        return (err < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp_sum(longint v);
        if (v > SUM_HI) begin
            return SUM_HI;
        end
        if (v < SUM_LO) begin
            return SUM_LO;
        end
        return v;
    endfunction

    function automatic void duty_from_volts(longint v, longint unsigned batt,
                                            output logic [15:0] duty,
                                            output logic [1:0] dir);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q = (gain_reg[ddpd_pkg::REG_FULL] * mag) / batt;
        dir = (q == 0) ? ddpd_pkg::DIR_KEEP :
              ((v < 0) ? ddpd_pkg::DIR_REV : ddpd_pkg::DIR_FWD);
        duty = (q > gain_reg[ddpd_pkg::REG_CEIL]) ? gain_reg[ddpd_pkg::REG_CEIL][15:0]
                                                   : q[15:0];
    endfunction

    function automatic t_drive predict_drive(t_tick t);
        t_drive d;
        longint nf;
        longint nr;
        longint fwd;
        longint rot;
        longint lv;
        longint rv;
        longint vmax;
        longint unsigned batt;
        d = '{written: 1'b1, l_duty: 16'd0, l_dir: ddpd_pkg::DIR_BRAKE, r_duty: 16'd0,
              r_dir: ddpd_pkg::DIR_BRAKE, l_volts: 17'd0, r_volts: 17'd0};
        if (t.action) begin
            return d;
        end
        batt = (t.batt == 0) ? 1 : t.batt;
        nf = fwd_sum + trunc_q16(longint'($signed(t.speed)) * gain_reg[ddpd_pkg::REG_TICK])
             - longint'($signed(t.moved_fwd));
        nr = rot_sum + trunc_q16(longint'($signed(t.turn)) * gain_reg[ddpd_pkg::REG_TICK])
             - longint'($signed(t.moved_rot));
        if (t.prof_idle) begin
            nr += longint'($signed(t.steer));
        end
        nf = clamp_sum(nf);
        nr = clamp_sum(nr);
        fwd = pd_volts(nf, gain_reg[ddpd_pkg::REG_FWD_P])
              + pd_volts(nf - fwd_sum, gain_reg[ddpd_pkg::REG_FWD_D]);
        rot = pd_volts(nr, gain_reg[ddpd_pkg::REG_ROT_P])
              + pd_volts(nr - rot_sum, gain_reg[ddpd_pkg::REG_ROT_D]);
        fwd_sum = nf;
        rot_sum = nr;
        vmax = gain_reg[ddpd_pkg::REG_VMAX];
        lv = fwd - rot;
        rv = fwd + rot;
        lv = (lv > vmax) ? vmax : ((lv < -vmax) ? -vmax : lv);
        rv = (rv > vmax) ? vmax : ((rv < -vmax) ? -vmax : rv);
        d.written = t.enable;
        d.l_duty = 0;
        d.l_dir = ddpd_pkg::DIR_KEEP;
        d.r_duty = 0;
        d.r_dir = ddpd_pkg::DIR_KEEP;
        if (t.enable) begin
            duty_from_volts(lv, batt, d.l_duty, d.l_dir);
            duty_from_volts(rv, batt, d.r_duty, d.r_dir);
        end
        d.l_volts = lv[16:0];
        d.r_volts = rv[16:0];
        return d;
    endfunction

    task automatic check_drive();
        t_drive e;
        if (expected_drives.size() == 0) begin
            $display("%0t: unexpected result, written=%0b", $time, drive_written);
            errors++;
        end else begin
            e = expected_drives.pop_front();
            if (drive_written !== e.written || left_duty !== e.l_duty ||
                left_dir !== e.l_dir || right_duty !== e.r_duty ||
                right_dir !== e.r_dir || left_volts !== e.l_volts ||
                right_volts !== e.r_volts) begin
                $display("%0t: mismatch expected w=%0b ld=%0d ldir=%0d rd=%0d rdir=%0d lv=%0d rv=%0d",
                         $time, e.written, e.l_duty, e.l_dir, e.r_duty, e.r_dir,
                         $signed(e.l_volts), $signed(e.r_volts));
                $display("%0t:          actual   w=%0b ld=%0d ldir=%0d rd=%0d rdir=%0d lv=%0d rv=%0d",
                         $time, drive_written, left_duty, left_dir, right_duty, right_dir,
                         left_volts, right_volts);
                errors++;
            end
        end
    endtask

    assign in_fire = in_valid && in_ready;

    // Monitor: predicts each tick as it is transferred and checks each result.
    always @(posedge clk) begin
        in_ready_seen <= in_fire;
        cycle_count <= cycle_count + 1;
        if (rst_n && in_fire) begin
            expected_drives.push_back(predict_drive(cur));
        end
        if (rst_n && out_valid && out_ready) begin
            check_drive();
        end
    end

    // Driver: presents queued ticks.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            // No tick is presented, or a transfer happened at the last rising edge; move on or idle.
            if (!in_valid || in_ready_seen) begin
                if (pending_ticks.size() != 0 && !hold_sender &&
                    $urandom_range(99, 0) >= send_idle_pct) begin
                    cur <= pending_ticks.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    task automatic apb_write(int idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 5'(4 * idx);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gain_reg[idx] = (idx >= ddpd_pkg::REG_VMAX) ? value[15:0] : value[23:0];
        if (prdata !== {8'd0, gain_reg[idx]} || pready !== 1'b1) begin
            $display("%0t: register %0d expected %0d actual %0d", $time, idx,
                     gain_reg[idx], prdata);
            errors++;
        end
    endtask

    task automatic drain();
        while (pending_ticks.size() != 0 || in_valid || expected_drives.size() != 0) begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
    endtask

    function automatic t_tick rand_tick(int well_formed);
        t_tick t;
        t.action = ($urandom_range(99, 0) < 4);
        t.speed = 24'($urandom());
        t.turn = 24'($urandom());
        t.steer = $urandom();
        t.moved_fwd = $urandom();
        t.moved_rot = $urandom();
        if (well_formed) begin
            t.speed = 24'($signed($urandom_range(4000, 0)) - 2000);
            t.turn = 24'($signed($urandom_range(4000, 0)) - 2000);
            t.steer = 32'($signed($urandom_range(400000, 0)) - 200000);
            t.moved_fwd = 32'($signed($urandom_range(400000, 0)) - 200000);
            t.moved_rot = 32'($signed($urandom_range(400000, 0)) - 200000);
        end
        t.prof_idle = 1'($urandom());
        t.enable = ($urandom_range(99, 0) < 85);
        t.batt = ($urandom_range(9, 0) == 0) ? 16'($urandom()) :
                 16'($urandom_range(40000, 20000));
        return t;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            pending_ticks.push_back(rand_tick($urandom_range(99, 0) < 80));
        end
        drain();
    endtask

    initial begin
        t_tick t;
        errors = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        hold_sender = 1'b0;
        in_ready_seen = 1'b0;
        cur = '{default: '0};
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 6;
        recv_stall_pct = 85;
        gain_reg = '{81626, 892517, 62790, 686550, 33554, 24576, 2047, 1473};
        fwd_sum = 0;
        rot_sum = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, stop, zero battery, large error sums.
        t = '{action: 0, speed: 24'h7FFFFF, turn: 24'h800000, steer: 32'h7FFFFFFF,
              moved_fwd: 32'h80000000, moved_rot: 32'h7FFFFFFF, prof_idle: 1,
              enable: 1, batt: 16'd0};
        pending_ticks.push_back(t);
        t.batt = 16'hFFFF;
        t.enable = 0;
        pending_ticks.push_back(t);
        t.action = 1;
        pending_ticks.push_back(t);
        t = '{action: 0, speed: 0, turn: 0, steer: 0, moved_fwd: 0, moved_rot: 0,
              prof_idle: 0, enable: 1, batt: 16'd1};
        pending_ticks.push_back(t);
        t.moved_fwd = 32'h80000000;
        t.moved_rot = 32'h7FFFFFFF;
        for (int i = 0; i < 8; i++) begin
            pending_ticks.push_back(t);
        end
        t.moved_fwd = 32'd16;
        t.moved_rot = 32'hFFFFFFF0;
        t.batt = 16'd32768;
        pending_ticks.push_back(t);
        drain();

        // Sums carry over from the directed ticks; no register write needs them cleared.
        apb_write(ddpd_pkg::REG_FWD_P, 32'h00FFFFFF);
        apb_write(ddpd_pkg::REG_FWD_D, 32'h0);
        apb_write(ddpd_pkg::REG_ROT_P, 32'h0);
        apb_write(ddpd_pkg::REG_ROT_D, 32'h00FFFFFF);
        apb_write(ddpd_pkg::REG_TICK, 32'h00FFFFFF);
        apb_write(ddpd_pkg::REG_VMAX, 32'h0000FFFF);
        apb_write(ddpd_pkg::REG_FULL, 32'h0000FFFF);
        apb_write(ddpd_pkg::REG_CEIL, 32'h0000FFFF);
        run_random(400);

        apb_write(ddpd_pkg::REG_FWD_P, 32'd0);
        apb_write(ddpd_pkg::REG_TICK, 32'd1);
        apb_write(ddpd_pkg::REG_VMAX, 32'd0);
        apb_write(ddpd_pkg::REG_FULL, 32'd1);
        apb_write(ddpd_pkg::REG_CEIL, 32'd0);
        run_random(150);

        send_idle_pct = 85;
        recv_stall_pct = 6;
        apb_write(ddpd_pkg::REG_FWD_P, 32'd81626);
        apb_write(ddpd_pkg::REG_FWD_D, 32'd892517);
        apb_write(ddpd_pkg::REG_ROT_P, 32'd62790);
        apb_write(ddpd_pkg::REG_ROT_D, 32'd686550);
        apb_write(ddpd_pkg::REG_TICK, 32'd33554);
        apb_write(ddpd_pkg::REG_VMAX, 32'd24576);
        apb_write(ddpd_pkg::REG_FULL, 32'd2047);
        apb_write(ddpd_pkg::REG_CEIL, 32'd1473);
        run_random(500);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 40; i++) begin
            pending_ticks.push_back(rand_tick(1));
        end
        // Part way through, hold the sender back until the block has gone quiet.
        while (pending_ticks.size() > 20) begin
            @(posedge clk);
        end
        hold_sender = 1'b1;
        while (in_valid || expected_drives.size() != 0) begin
            @(posedge clk);
        end
        @(posedge clk);
        hold_sender = 1'b0;
        run_random(540);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    always @(posedge clk) begin
        if (cycle_count > 2000000) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

// ===== differential_drive_pd_controller_core.f =====
sv/ddpd_pkg.sv
sv/ddpd_ctrl.sv
sv/ddpd_datapath.sv
sv/differential_drive_pd_controller_core.sv
tb/tb_differential_drive_pd_controller_core.sv
